// ===== sv/connectivity_under_vertex_removal_assert.svh =====
// ----------------------------------------------------------------------------
// connectivity under vertex removal - assertion macros
// shared concurrent assertion forms, clocked on clk and disabled in reset
// ----------------------------------------------------------------------------
`ifndef CONNECTIVITY_UNDER_VERTEX_REMOVAL_ASSERT_SVH
`define CONNECTIVITY_UNDER_VERTEX_REMOVAL_ASSERT_SVH

// property holds at every edge outside reset
`define CUVR_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

// consequent holds in the cycle after the antecedent
`define CUVR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/cuvr_pkg.sv =====
// ----------------------------------------------------------------------------
// cuvr_pkg
// shared constants for the connectivity under vertex removal block
// ----------------------------------------------------------------------------
package cuvr_pkg;

  localparam int MAX_VERTICES_DEF = 32;
  localparam int ROW_W            = 32;
  localparam int ROW_INDEX_W      = 5;
  localparam int VC_W             = 6;
  localparam logic [VC_W-1:0] VC_RESET = 6'd32;

  // input tdata layout, lowest bit first
  localparam int ROW_INDEX_LSB = 0;
  localparam int NROW_LSB      = ROW_INDEX_LSB + ROW_INDEX_W;
  localparam int RMASK_LSB     = NROW_LSB + ROW_W;
  localparam int IN_TDATA_W    = 72;
  localparam int OUT_TDATA_W   = 8;

  localparam logic CMD_LOAD  = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

endpackage

// ===== sv/connectivity_under_vertex_removal.sv =====
// ----------------------------------------------------------------------------
// connectivity_under_vertex_removal
// graph adjacency store with a reachability walk under a removed-vertex mask
// ----------------------------------------------------------------------------
// usage:
//   in_* is a stream slave. in_tuser is the command: load writes adjacency
//   row row_index, query walks the stored graph with removed_mask applied.
//   out_* is a stream master with one transfer per input transfer:
//   out_tuser is is_answer, out_tdata carries connected and none_left.
//   cfg_* writes vertex_count at any time the block is idle; always ready.
// flow:
//   a load, or a query with every vertex removed, has its result registered
//   and goes straight to the output state. a walking query expands the
//   reached vertices one at a time on the single read port of the adjacency
//   ram: the row of the lowest pending vertex is read while the row that
//   arrived is merged, and a vertex found in the row being merged is picked
//   only after that merge.
//   in_tready is high only while no item is in work.
// reset:
//   rst_n clears the row valid bits (every row reads as zero), the reached and
//   pending sets and the output valid, and sets vertex_count to 32.
// stall:
//   a result holds in the output register until taken; the next item is
//   accepted meanwhile and its result waits in the block.
// ----------------------------------------------------------------------------
`include "connectivity_under_vertex_removal_assert.svh"

module connectivity_under_vertex_removal #(
  parameter int MAX_VERTICES = cuvr_pkg::MAX_VERTICES_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  // row_index[4:0], neighbour_row[36:5], removed_mask[68:37], zeros above
  input  logic [cuvr_pkg::IN_TDATA_W-1:0]  in_tdata,
  // command
  input  logic                             in_tuser,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // connected[0], none_left[1], zeros above
  output logic [cuvr_pkg::OUT_TDATA_W-1:0] out_tdata,
  // is_answer
  output logic                             out_tuser,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [cuvr_pkg::VC_W-1:0]        cfg_data
);
  import cuvr_pkg::*;

  localparam int MV        = MAX_VERTICES;
  localparam int VW        = $clog2(MV);
  localparam int ROW_DEPTH = (MV < ROW_W) ? MV : ROW_W;
  localparam int AW        = $clog2(ROW_DEPTH);
  localparam logic [MV-1:0] VONE = {{(MV-1){1'b0}}, 1'b1};

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_RUN  = 2'd1;
  localparam logic [1:0] ST_OUT  = 2'd2;

  logic [1:0]      state_r, state_nxt;
  logic [VC_W-1:0] vc_r;
  logic [MV-1:0]   alive_r, alive_nxt;
  logic [MV-1:0]   reached_r, reached_nxt;
  logic [MV-1:0]   pending_r, pending_nxt;
  logic            inflight_r, inflight_nxt;
  logic            rd_ok_r, rd_ok_nxt;
  logic            res_answer_r, res_answer_nxt;
  logic            res_conn_r, res_conn_nxt;
  logic            res_none_r, res_none_nxt;
  logic            out_valid_r, out_valid_nxt;
  logic            out_answer_r, out_answer_nxt;
  logic            out_conn_r, out_conn_nxt;
  logic            out_none_r, out_none_nxt;
  logic [ROW_DEPTH-1:0] row_valid_r;

  // input fields
  logic                   command;
  logic [ROW_INDEX_W-1:0] row_index;
  logic [ROW_W-1:0]       neighbour_row;
  logic [ROW_W-1:0]       removed_mask;

  logic [63:0]   rm64, row64;
  logic [MV-1:0] in_use, alive_in, start_in, removed_ext;
  logic [MV-1:0] pick_iso, row_ext, fresh;
  logic [VW-1:0] pick_idx;
  logic          pick_in_range, load_in_range;
  logic          ram_we;
  logic [ROW_W-1:0] ram_rdata;

  assign command       = in_tuser;
  assign row_index     = in_tdata[ROW_INDEX_LSB +: ROW_INDEX_W];
  assign neighbour_row = in_tdata[NROW_LSB +: ROW_W];
  assign removed_mask  = in_tdata[RMASK_LSB +: ROW_W];

  assign in_tready  = (state_r == ST_IDLE);
  assign cfg_ready  = 1'b1;
  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_answer_r;
  assign out_tdata  = {{(OUT_TDATA_W-2){1'b0}}, out_none_r, out_conn_r};

  // masks over the vertices in use
  always_comb begin
    for (int i = 0; i < MV; i++) begin
      in_use[i] = (vc_r > VC_W'(i));
    end
  end

  assign rm64        = {32'b0, removed_mask};
  assign removed_ext = rm64[MV-1:0];
  assign alive_in    = in_use & ~removed_ext;
  assign start_in    = alive_in & (~alive_in + VONE);

  // lowest pending vertex
  assign pick_iso = pending_r & (~pending_r + VONE);
  always_comb begin
    pick_idx = '0;
    for (int i = 0; i < MV; i++) begin
      if (pick_iso[i]) begin
        pick_idx = pick_idx | VW'(i);
      end
    end
  end

  assign pick_in_range = ({1'b0, pick_idx} < (VW+1)'(ROW_DEPTH));
  assign load_in_range = ({2'b0, row_index} < 7'(MV));

  // rows past the store or never loaded read as zero
  assign row64   = {32'b0, ram_rdata};
  assign row_ext = row64[MV-1:0] & {MV{rd_ok_r}};
  assign fresh   = inflight_r ? (row_ext & alive_r & ~reached_r) : '0;

  always_comb begin
    state_nxt      = state_r;
    alive_nxt      = alive_r;
    reached_nxt    = reached_r;
    pending_nxt    = pending_r;
    inflight_nxt   = inflight_r;
    rd_ok_nxt      = rd_ok_r;
    res_answer_nxt = res_answer_r;
    res_conn_nxt   = res_conn_r;
    res_none_nxt   = res_none_r;
    out_valid_nxt  = out_valid_r && !out_tready;
    out_answer_nxt = out_answer_r;
    out_conn_nxt   = out_conn_r;
    out_none_nxt   = out_none_r;
    ram_we         = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          if (command == CMD_LOAD) begin
            ram_we         = load_in_range;
            res_answer_nxt = 1'b0;
            res_conn_nxt   = 1'b0;
            res_none_nxt   = 1'b0;
            state_nxt      = ST_OUT;
          end else begin
            alive_nxt      = alive_in;
            res_answer_nxt = 1'b1;
            if (alive_in == '0) begin
              reached_nxt  = '0;
              pending_nxt  = '0;
              res_conn_nxt = 1'b0;
              res_none_nxt = 1'b1;
              state_nxt    = ST_OUT;
            end else begin
              reached_nxt  = start_in;
              pending_nxt  = start_in;
              inflight_nxt = 1'b0;
              state_nxt    = ST_RUN;
            end
          end
        end
      end
      ST_RUN: begin
        // issue the next row read while merging the one that arrived
        inflight_nxt = (pending_r != '0);
        rd_ok_nxt    = pick_in_range && row_valid_r[pick_idx[AW-1:0]];
        pending_nxt  = (pending_r & ~pick_iso) | fresh;
        reached_nxt  = reached_r | fresh;
        if (pending_r == '0 && !inflight_r) begin
          res_conn_nxt = (reached_r == alive_r);
          res_none_nxt = 1'b0;
          state_nxt    = ST_OUT;
        end
      end
      ST_OUT: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt  = 1'b1;
          out_answer_nxt = res_answer_r;
          out_conn_nxt   = res_conn_r;
          out_none_nxt   = res_none_r;
          state_nxt      = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      vc_r        <= VC_RESET;
      reached_r   <= '0;
      pending_r   <= '0;
      inflight_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      reached_r   <= reached_nxt;
      pending_r   <= pending_nxt;
      inflight_r  <= inflight_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        vc_r <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    alive_r      <= alive_nxt;
    rd_ok_r      <= rd_ok_nxt;
    res_answer_r <= res_answer_nxt;
    res_conn_r   <= res_conn_nxt;
    res_none_r   <= res_none_nxt;
    out_answer_r <= out_answer_nxt;
    out_conn_r   <= out_conn_nxt;
    out_none_r   <= out_none_nxt;
  end

  // one valid bit per row, all rows read as zero after reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_valid_r <= '0;
    end else if (ram_we) begin
      row_valid_r[row_index[AW-1:0]] <= 1'b1;
    end
  end

  cuvr_ram #(
    .WIDTH (ROW_W),
    .DEPTH (ROW_DEPTH)
  ) u_rows (
    .clk   (clk),
    .we    (ram_we),
    .waddr (row_index[AW-1:0]),
    .wdata (neighbour_row),
    .raddr (pick_idx[AW-1:0]),
    .rdata (ram_rdata)
  );

  `CUVR_ASSERT(a_pending_in_reached, (pending_r & ~reached_r) == '0, "pending vertex not reached")
  `CUVR_ASSERT(a_reached_alive, (state_r == ST_RUN) |-> ((reached_r & ~alive_r) == '0), "reached a dead vertex")
  `CUVR_ASSERT(a_inflight_run, inflight_r |-> (state_r == ST_RUN), "row read outside walk")
  `CUVR_ASSERT_NEXT(a_walk_done, state_r == ST_RUN && pending_r == '0 && !inflight_r, state_r == ST_OUT, "walk did not finish")

endmodule

// ===== sv/cuvr_ram.sv =====
// ----------------------------------------------------------------------------
// cuvr_ram
// generic single write port, single read port ram with registered read
// ----------------------------------------------------------------------------
module cuvr_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== sim/connectivity_under_vertex_removal_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// connectivity_under_vertex_removal_tb
// loads adjacency rows and asks connectivity queries under random removal
// masks; every returned verdict is checked against an in-bench walk of the
// same graph, with random gaps on both streams and long output stalls
// ----------------------------------------------------------------------------
module connectivity_under_vertex_removal_tb;
  import cuvr_pkg::*;

  localparam int CONNECTED_BIT = 0;
  localparam int NONE_LEFT_BIT = 1;
  localparam int MAX_GAP       = 18;
  localparam int RANDOM_ITEMS  = 600;
  localparam int REPORT_LIMIT  = 10;

  typedef struct packed {
    logic is_answer;
    logic connected;
    logic none_left;
  } verdict_t;

  logic                   clk        = 1'b0;
  logic                   rst_n      = 1'b0;
  logic                   in_tvalid  = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata   = '0;
  logic                   in_tuser   = CMD_LOAD;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   out_tuser;
  logic                   cfg_valid  = 1'b0;
  logic                   cfg_ready;
  logic [VC_W-1:0]        cfg_data   = '0;

  // shadow of the block state
  logic [ROW_W-1:0] adj_rows [MAX_VERTICES_DEF] = '{default: '0};
  logic [VC_W-1:0]  vcount_model = VC_RESET;
  verdict_t         owed_verdicts [$];

  int fail_count   = 0;
  bit in_idle_on   = 1'b1;
  bit out_idle_on  = 1'b1;
  int rx_stall     = 0;
  int hold_request = 0;
  int hold_left    = 0;

  connectivity_under_vertex_removal #(
    .MAX_VERTICES(MAX_VERTICES_DEF)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic [ROW_W-1:0] use_mask(input logic [VC_W-1:0] vc);
    int n;
    n = (vc > MAX_VERTICES_DEF) ? MAX_VERTICES_DEF : int'(vc);
    if (n >= ROW_W) return '1;
    return (ROW_W'(1) << n) - ROW_W'(1);
  endfunction

  // layer-by-layer walk from the lowest surviving vertex
  function automatic verdict_t predict_connectivity(input logic [ROW_W-1:0] removed);
    verdict_t         v;
    logic [ROW_W-1:0] alive, seen, frontier, fresh;
    v = '0;
    v.is_answer = 1'b1;
    alive = use_mask(vcount_model) & ~removed;
    if (alive == '0) begin
      v.none_left = 1'b1;
      return v;
    end
    seen = alive & (~alive + ROW_W'(1));
    frontier = seen;
    while (frontier != '0) begin
      fresh = '0;
      for (int k = 0; k < ROW_W; k++)
        if (frontier[k]) fresh |= adj_rows[k];
      frontier = fresh & alive & ~seen;
      seen |= frontier;
    end
    v.connected = (seen == alive);
    return v;
  endfunction

  function automatic logic [ROW_W-1:0] draw_removed();
    logic [ROW_W-1:0] inuse, m;
    int               nv;
    inuse = use_mask(vcount_model);
    nv = $countones(inuse);
    m = '0;
    case ($urandom_range(0, 9))
      0, 1: m = '0;
      2, 3, 4: begin
        if (nv > 0)
          repeat ($urandom_range(1, 3)) m[$urandom_range(0, nv - 1)] = 1'b1;
      end
      5, 6: m = $urandom() & $urandom();
      7: m = $urandom();
      8: m = inuse;
      default: begin
        // a lone survivor
        m = inuse;
        if (nv > 0) m[$urandom_range(0, nv - 1)] = 1'b0;
      end
    endcase
    // bits beyond the vertices in use must be ignored
    if ($urandom_range(0, 1)) m |= $urandom() & ~inuse;
    return m;
  endfunction

  task automatic send_item(input logic cmd, input logic [ROW_INDEX_W-1:0] row_idx,
                           input logic [ROW_W-1:0] row_bits,
                           input logic [ROW_W-1:0] removed);
    int                    gap;
    logic [IN_TDATA_W-1:0] word;
    gap = in_idle_on ? $urandom_range(0, MAX_GAP) : 0;
    word = '0;
    word[ROW_INDEX_LSB +: ROW_INDEX_W] = row_idx;
    word[NROW_LSB +: ROW_W] = row_bits;
    word[RMASK_LSB +: ROW_W] = removed;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= cmd;
    in_tdata  <= word;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    // transfer taken at this edge
    if (cmd == CMD_LOAD) begin
      adj_rows[row_idx] = row_bits;
      owed_verdicts.push_back(verdict_t'('0));
    end else begin
      owed_verdicts.push_back(predict_connectivity(removed));
    end
  endtask

  task automatic wait_drained();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (owed_verdicts.size() != 0) @(posedge clk);
  endtask

  task automatic write_vertex_count(input logic [VC_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    vcount_model = value;
  endtask

  task automatic check_verdict(input logic got_answer,
                               input logic [OUT_TDATA_W-1:0] got_data);
    verdict_t want;
    if (owed_verdicts.size() == 0) begin
      fail_count++;
      if (fail_count <= REPORT_LIMIT)
        $display("%0t: result with nothing owed: is_answer=%0b connected=%0b none_left=%0b",
                 $time, got_answer, got_data[CONNECTED_BIT], got_data[NONE_LEFT_BIT]);
      return;
    end
    want = owed_verdicts.pop_front();
    if (got_answer !== want.is_answer || got_data[CONNECTED_BIT] !== want.connected ||
        got_data[NONE_LEFT_BIT] !== want.none_left) begin
      fail_count++;
      if (fail_count <= REPORT_LIMIT)
        $display("%0t: verdict mismatch: expected is_answer=%0b connected=%0b none_left=%0b, %s",
                 $time, want.is_answer, want.connected, want.none_left,
                 $sformatf("got is_answer=%0b connected=%0b none_left=%0b", got_answer,
                           got_data[CONNECTED_BIT], got_data[NONE_LEFT_BIT]));
    end
  endtask

  // long output hold-off, counted here
  always @(posedge clk) begin
    if (hold_request > 0) begin
      hold_left    <= hold_request;
      hold_request <= 0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
      rx_stall = 0;
    end else begin
      if (out_tvalid && out_tready) begin
        check_verdict(out_tuser, out_tdata);
        rx_stall = out_idle_on ? $urandom_range(0, MAX_GAP) : 0;
      end else if (rx_stall > 0) begin
        rx_stall--;
      end
      out_tready <= (rx_stall == 0) && (hold_left == 0);
    end
  end

  task automatic test_cleared_store();
    send_item(CMD_QUERY, 5'd0, '0, '0);
    send_item(CMD_QUERY, 5'd31, '1, '1);
    send_item(CMD_QUERY, 5'd0, '0, 32'h7fff_ffff);
    send_item(CMD_LOAD, 5'd0, '1, '1);
    send_item(CMD_QUERY, 5'd0, '0, '0);
    send_item(CMD_LOAD, 5'd31, '1, '0);
    send_item(CMD_QUERY, 5'd0, '0, 32'h0000_0001);
  endtask

  task automatic test_edge_direction();
    wait_drained();
    write_vertex_count(6'd2);
    send_item(CMD_LOAD, 5'd0, 32'h0000_0002, $urandom());
    send_item(CMD_LOAD, 5'd1, '0, $urandom());
    send_item(CMD_QUERY, ROW_INDEX_W'($urandom()), $urandom(), '0);
    // self loop on the start vertex, edge back from vertex 1 only
    send_item(CMD_LOAD, 5'd0, 32'h0000_0001, $urandom());
    send_item(CMD_LOAD, 5'd1, 32'h0000_0001, $urandom());
    send_item(CMD_QUERY, ROW_INDEX_W'($urandom()), $urandom(), '0);
    send_item(CMD_QUERY, ROW_INDEX_W'($urandom()), $urandom(), 32'h0000_0001);
    send_item(CMD_QUERY, ROW_INDEX_W'($urandom()), $urandom(), 32'hffff_fffc);
  endtask

  task automatic test_vertex_count_edges();
    wait_drained();
    write_vertex_count(6'd1);
    send_item(CMD_QUERY, ROW_INDEX_W'($urandom()), $urandom(), 32'hffff_fffe);
    send_item(CMD_QUERY, ROW_INDEX_W'($urandom()), $urandom(), 32'h0000_0001);
    wait_drained();
    write_vertex_count(6'd0);
    send_item(CMD_QUERY, ROW_INDEX_W'($urandom()), $urandom(), '0);
    send_item(CMD_LOAD, 5'd5, $urandom(), $urandom());
    wait_drained();
    // above the store size, taken as a full store
    write_vertex_count(6'd63);
    send_item(CMD_QUERY, ROW_INDEX_W'($urandom()), $urandom(), 32'h7fff_fffe);
    wait_drained();
    write_vertex_count(6'd33);
    send_item(CMD_LOAD, 5'd0, 32'h8000_0001, $urandom());
    send_item(CMD_QUERY, ROW_INDEX_W'($urandom()), $urandom(), 32'h7fff_fffe);
  endtask

  task automatic test_output_holdoff(input int hold);
    wait_drained();
    in_idle_on = 1'b0;
    hold_request <= hold;
    repeat (12) begin
      if ($urandom_range(0, 3) == 0)
        send_item(CMD_LOAD, ROW_INDEX_W'($urandom()), $urandom() & $urandom(), $urandom());
      else
        send_item(CMD_QUERY, ROW_INDEX_W'($urandom()), $urandom(), draw_removed());
    end
    wait_drained();
  endtask

  task automatic test_random_graphs();
    int               items, nv, density, j;
    bit               symmetric, spanning;
    logic [VC_W-1:0]  vc;
    logic [ROW_W-1:0] rows [MAX_VERTICES_DEF];
    items = 0;
    while (items < RANDOM_ITEMS) begin
      wait_drained();
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4: vc = VC_W'($urandom_range(1, 10));
        5, 6, 7: vc = VC_W'($urandom_range(11, 32));
        8: vc = VC_W'(MAX_VERTICES_DEF);
        default: vc = VC_W'($urandom_range(0, 1) ? 0 : $urandom_range(33, 63));
      endcase
      write_vertex_count(vc);
      in_idle_on  = ($urandom_range(0, 2) != 0);
      out_idle_on = ($urandom_range(0, 2) != 0);

      nv = $countones(use_mask(vc));
      case ($urandom_range(0, 3))
        0: density = 5;
        1: density = 15;
        2: density = 35;
        default: density = 70;
      endcase
      symmetric = ($urandom_range(0, 3) != 0);
      spanning  = ($urandom_range(0, 1) != 0);
      foreach (rows[i]) rows[i] = '0;
      for (int a = 0; a < nv; a++)
        for (int b = 0; b < nv; b++)
          if ($urandom_range(1, 100) <= density) begin
            rows[a][b] = 1'b1;
            if (symmetric) rows[b][a] = 1'b1;
          end
      // tree edges so that most walks reach far
      if (spanning)
        for (int a = 1; a < nv; a++) begin
          j = $urandom_range(0, a - 1);
          rows[j][a] = 1'b1;
          if (symmetric) rows[a][j] = 1'b1;
        end

      for (int a = 0; a < MAX_VERTICES_DEF; a++)
        if (a < nv || $urandom_range(0, 7) == 0) begin
          if ($urandom_range(0, 1)) rows[a] |= $urandom() & ~use_mask(vc);
          send_item(CMD_LOAD, ROW_INDEX_W'(a), rows[a], $urandom());
          items++;
        end

      repeat ($urandom_range(8, 24)) begin
        if ($urandom_range(0, 9) == 0)
          send_item(CMD_LOAD, ROW_INDEX_W'($urandom()), $urandom() & $urandom(), $urandom());
        else
          send_item(CMD_QUERY, ROW_INDEX_W'($urandom()), $urandom(), draw_removed());
        items++;
      end
    end
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_cleared_store();
    test_edge_direction();
    test_vertex_count_edges();
    test_output_holdoff(300);
    test_random_graphs();
    test_output_holdoff(500);
    wait_drained();
    repeat (50) @(posedge clk);
    if (fail_count == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

  initial begin
    #3_000_000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule
